// ===== design/bls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg
// shared command codes, status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package bls_pkg;

	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_POP     = 2'd1;
	localparam logic [1:0] CMD_PEEK    = 2'd2;
	localparam logic [1:0] CMD_DISPLAY = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	localparam int WORD_W = 32;

	// controller to datapath
	typedef struct packed {
		logic       push;     // write value at count, count up
		logic       pop;      // count down
		logic       rd_top;   // read entry count-1, load walk pointer
		logic       rd_next;  // read entry below walk pointer
		logic       emit;     // present a result next cycle
		logic       sel_data; // result carries the word read
		logic       last;
		logic [1:0] status;
	} bls_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic one;     // exactly one entry stored
		logic ptr_one; // next walk read is the bottom entry
	} bls_stat_t;

endpackage

// ===== design/bls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/bls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_ctrl
// command decode and display walk state machine
// ----------------------------------------------------------------------------
module bls_ctrl
	import bls_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [1:0] command,
	input  bls_stat_t stat,
	output logic      busy,
	output bls_cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_WALK = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					case (command)
						CMD_PUSH: begin
							if (stat.full) begin
								cmd.status = ST_OVERFLOW;
							end else begin
								cmd.push   = 1'b1;
								cmd.status = ST_OK;
							end
						end
						CMD_POP, CMD_PEEK: begin
							if (stat.empty) begin
								cmd.status = ST_EMPTY;
							end else begin
								cmd.rd_top   = 1'b1;
								cmd.pop      = (command == CMD_POP);
								cmd.sel_data = 1'b1;
								cmd.status   = ST_OK;
							end
						end
						CMD_DISPLAY: begin
							if (stat.empty) begin
								cmd.status = ST_EMPTY;
							end else begin
								cmd.rd_top   = 1'b1;
								cmd.sel_data = 1'b1;
								cmd.status   = ST_OK;
								cmd.last     = stat.one;
								if (!stat.one) begin
									state_d = S_WALK;
								end
							end
						end
						default: begin
							cmd.status = ST_EMPTY;
						end
					endcase
				end
			end
			S_WALK: begin
				cmd.rd_next  = 1'b1;
				cmd.emit     = 1'b1;
				cmd.sel_data = 1'b1;
				cmd.status   = ST_OK;
				cmd.last     = stat.ptr_one;
				if (stat.ptr_one) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == S_WALK);

endmodule

// ===== design/bls_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_dp
// entry memory, fill count, walk pointer and result registers
// ----------------------------------------------------------------------------
module bls_dp
	import bls_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bls_cmd_t                 cmd,
	input  logic signed [WORD_W-1:0] value,
	output bls_stat_t                stat,
	output logic                     strobe,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] data,
	output logic                     is_empty,
	output logic                     is_full,
	output logic                     last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic [CW-1:0]     count_m1;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     ptr_m1;
	logic [AW-1:0]     raddr;
	logic              re;
	logic [WORD_W-1:0] rdata;

	logic              strobe_q;
	logic [1:0]        status_q;
	logic              last_q;
	logic              sel_q;
	logic              empty_q;
	logic              full_q;

	assign count_m1 = count_q - CW'(1);
	assign ptr_m1   = ptr_q - AW'(1);
	assign re       = cmd.rd_top | cmd.rd_next;
	assign raddr    = cmd.rd_next ? ptr_m1 : count_m1[AW-1:0];

	always_comb begin
		count_d = count_q;
		if (cmd.push) begin
			count_d = count_q + CW'(1);
		end else if (cmd.pop) begin
			count_d = count_m1;
		end
	end

	bls_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (count_q[AW-1:0]),
		.wdata ($unsigned(value)),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			strobe_q <= 1'b0;
			empty_q  <= 1'b1;
			full_q   <= 1'b0;
			sel_q    <= 1'b0;
		end else begin
			count_q  <= count_d;
			strobe_q <= cmd.emit;
			empty_q  <= (count_d == '0);
			full_q   <= (count_d == FULL_CNT);
			sel_q    <= cmd.sel_data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			ptr_q <= raddr;
		end
		if (cmd.emit) begin
			status_q <= cmd.status;
			last_q   <= cmd.last;
		end
	end

	assign stat.empty   = (count_q == '0);
	assign stat.full    = (count_q == FULL_CNT);
	assign stat.one     = (count_q == CW'(1));
	assign stat.ptr_one = (ptr_q == AW'(1));

	assign strobe   = strobe_q;
	assign status   = status_q;
	assign data     = sel_q ? $signed(rdata) : '0;
	assign is_empty = empty_q;
	assign is_full  = full_q;
	assign last     = last_q;

endmodule

// ===== design/bounded_lifo_stack_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_lifo_stack_unit
// fixed-depth last-in first-out stack of signed 32-bit words
// ----------------------------------------------------------------------------
// a command is taken when start is high and busy is low. its result shows on
// the result ports for exactly one cycle, marked by strobe, in the cycle after
// the command is taken; the receiver cannot stall, so every strobe must be
// captured. push, pop and peek never raise busy, so a new command may follow
// straight away. display returns one result per stored word, top first, with
// last set on the bottom word (a single empty-status result when the stack is
// empty): the single read port of the entry memory gives one word a cycle, and
// busy stays high until the final read has been issued.
// every result carries is_empty and is_full for the stack after the command
// ----------------------------------------------------------------------------
module bounded_lifo_stack_unit
	import bls_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command transaction
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               command,
	input  logic signed [WORD_W-1:0] value,
	// result transaction
	output logic                     strobe,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] data,
	output logic                     is_empty,
	output logic                     is_full,
	output logic                     last
);

	// decoded commands to the datapath and its flags back
	bls_cmd_t  cmd;
	bls_stat_t stat;

	// sequencer: push, pop and peek commands and the display walk
	bls_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.busy    (busy),
		.cmd     (cmd)
	);

	// storage, fill count and result registers
	bls_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (value),
		.stat     (stat),
		.strobe   (strobe),
		.status   (status),
		.data     (data),
		.is_empty (is_empty),
		.is_full  (is_full),
		.last     (last)
	);

	// every accepted command answers in the next cycle
	a_cmd_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe)
		else $error("accepted command gave no result");

	// a display walk produces a word every cycle
	a_walk_streams: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("display walk skipped a cycle");

	// only a display with more words to come leaves last clear
	a_not_last_walks: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result outside a display walk");

	// error results carry no word and end the transaction
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != ST_OK |-> data == '0 && last)
		else $error("error result with data or without last");

	// the stack cannot be empty and full at once
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(is_empty && is_full))
		else $error("empty and full flags both set");

endmodule

// ===== bench/bls_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_checker
// watches both sides of the stack unit, predicts its results and compares
// ----------------------------------------------------------------------------
// every accepted command runs through a behavioural stack that mirrors the
// unit; each strobed result is checked field by field against the oldest
// expected result. mismatches and stray results raise the failure count
// ----------------------------------------------------------------------------
module bls_checker
	import bls_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [1:0]               command,
	input  logic signed [WORD_W-1:0] value,
	input  logic                     strobe,
	input  logic [1:0]               status,
	input  logic signed [WORD_W-1:0] data,
	input  logic                     is_empty,
	input  logic                     is_full,
	input  logic                     last,
	output int                       fail_count,
	output int                       outstanding
);

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] data;
		logic                     is_empty;
		logic                     is_full;
		logic                     last;
	} stack_result_t;

	stack_result_t            results_due[$];
	logic signed [WORD_W-1:0] stack_words[DEPTH];
	int                       stored_count;

	initial begin
		fail_count   = 0;
		outstanding  = 0;
		stored_count = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// flags always reflect the stack after the command has taken effect
	task automatic add_result(input logic [1:0] st, input logic signed [WORD_W-1:0] word,
			input logic fin);
		stack_result_t r;
		r.status   = st;
		r.data     = word;
		r.is_empty = (stored_count == 0);
		r.is_full  = (stored_count == DEPTH);
		r.last     = fin;
		results_due.push_back(r);
	endtask

	task automatic predict_command(input logic [1:0] cmd, input logic signed [WORD_W-1:0] word);
		int n;
		case (cmd)
			CMD_PUSH: begin
				if (stored_count == DEPTH) begin
					add_result(ST_OVERFLOW, '0, 1'b1);
				end else begin
					stack_words[stored_count] = word;
					stored_count++;
					add_result(ST_OK, '0, 1'b1);
				end
			end
			CMD_POP: begin
				if (stored_count == 0) begin
					add_result(ST_EMPTY, '0, 1'b1);
				end else begin
					stored_count--;
					add_result(ST_OK, stack_words[stored_count], 1'b1);
				end
			end
			CMD_PEEK: begin
				if (stored_count == 0)
					add_result(ST_EMPTY, '0, 1'b1);
				else
					add_result(ST_OK, stack_words[stored_count-1], 1'b1);
			end
			default: begin
				if (stored_count == 0) begin
					add_result(ST_EMPTY, '0, 1'b1);
				end else begin
					n = stored_count;
					for (int k = 0; k < n; k++)
						add_result(ST_OK, stack_words[n-1-k], k == n - 1);
				end
			end
		endcase
	endtask

	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n) begin
			// results belong to earlier transactions, so check before predicting
			if (strobe === 1'b1) begin
				if (results_due.size() == 0) begin
					report_mismatch("unexpected result", data, '0);
				end else begin
					want = results_due.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (data !== want.data)
						report_mismatch("data", data, want.data);
					if (is_empty !== want.is_empty)
						report_mismatch("is_empty", is_empty, want.is_empty);
					if (is_full !== want.is_full)
						report_mismatch("is_full", is_full, want.is_full);
					if (last !== want.last)
						report_mismatch("last", last, want.last);
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				predict_command(command, value);
		end
		outstanding <= results_due.size();
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the bounded lifo stack unit
// ----------------------------------------------------------------------------
// a directed pass walks the stack through empty, full, overflow and back to
// empty, then random commands alternate between filling and draining phases
// so that both bounds are hit again and again. gaps between commands come in
// random bursts, none in the final stretch. checking is left to bls_checker
// ----------------------------------------------------------------------------
module tb_top
	import bls_pkg::*;
;

	localparam int DEPTH        = 8;
	localparam int RANDOM_ITEMS = 300;
	localparam int QUIET_ITEMS  = 60;     // no gaps in the final stretch
	localparam int CYCLE_LIMIT  = 200000; // far beyond the slowest legal run

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               command;
	logic signed [WORD_W-1:0] value;
	logic                     strobe;
	logic [1:0]               status;
	logic signed [WORD_W-1:0] data;
	logic                     is_empty;
	logic                     is_full;
	logic                     last;
	int                       fail_count;
	int                       outstanding;
	int                       cycle_count = 0;

	bounded_lifo_stack_unit #(
		.DEPTH(DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.command (command),
		.value   (value),
		.strobe  (strobe),
		.status  (status),
		.data    (data),
		.is_empty(is_empty),
		.is_full (is_full),
		.last    (last)
	);

	bls_checker #(
		.DEPTH(DEPTH)
	) stack_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.value      (value),
		.strobe     (strobe),
		.status     (status),
		.data       (data),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.last       (last),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// present one command and hold it until the unit takes the transaction;
	// start is left high so a following command can go straight out
	task automatic issue(input logic [1:0] cmd, input logic signed [WORD_W-1:0] word);
		@(negedge clk);
		start   <= 1'b1;
		command <= cmd;
		value   <= word;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// drop start for a burst of random length, with noise on the payload
	task automatic idle_burst();
		int n;
		n = $urandom_range(1, 7);
		@(negedge clk);
		start   <= 1'b0;
		command <= 2'($urandom);
		value   <= $urandom;
		repeat (n) @(posedge clk);
	endtask

	// mostly plain random words, with the corners of the range mixed in
	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       pick_word = 32'h7fff_ffff;
			1:       pick_word = 32'h8000_0000;
			2:       pick_word = '0;
			3:       pick_word = '1;
			default: pick_word = $urandom;
		endcase
	endfunction

	initial begin
		int   roll;
		int   phase_left;
		logic filling;
		logic [1:0] cmd;

		arst_n  = 1'b0;
		start   = 1'b0;
		command = CMD_PUSH;
		value   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty stack corners first
		issue(CMD_DISPLAY, 32'h1234_5678);
		issue(CMD_POP, '0);
		issue(CMD_PEEK, '1);
		// fill with extreme words up to the bound
		issue(CMD_PUSH, 32'h7fff_ffff);
		issue(CMD_PUSH, 32'h8000_0000);
		issue(CMD_PEEK, '0);
		issue(CMD_PUSH, '0);
		issue(CMD_PUSH, '1);
		issue(CMD_PUSH, 32'haaaa_aaaa);
		issue(CMD_PUSH, 32'h5555_5555);
		issue(CMD_PUSH, 32'h0000_0001);
		issue(CMD_PUSH, 32'hfffe_0000);
		// full: overflow, then a full-depth walk
		issue(CMD_PUSH, 32'hdead_beef);
		issue(CMD_DISPLAY, '0);
		issue(CMD_PEEK, '0);
		// drain past empty
		repeat (DEPTH + 1) issue(CMD_POP, $urandom);
		issue(CMD_DISPLAY, '0);

		// random: alternate fill and drain phases so both bounds recur
		filling    = 1'b1;
		phase_left = $urandom_range(8, 24);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (phase_left == 0) begin
				filling    = ~filling;
				phase_left = $urandom_range(8, 24);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if (filling)
				cmd = (roll < 60) ? CMD_PUSH : (roll < 75) ? CMD_POP :
					(roll < 87) ? CMD_PEEK : CMD_DISPLAY;
			else
				cmd = (roll < 15) ? CMD_PUSH : (roll < 65) ? CMD_POP :
					(roll < 80) ? CMD_PEEK : CMD_DISPLAY;
			if (i < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 3) == 0)
				idle_burst();
			issue(cmd, pick_word());
		end

		@(negedge clk);
		start <= 1'b0;

		// wait for every expected result, then a little slack for stray strobes
		do @(posedge clk); while (outstanding != 0);
		repeat (DEPTH + 4) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
